### rtl/core/integrity_tree_node_address_walk_defines.svh
// ----------------------------------------------------------------------------
// Integrity tree node address walk - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef INTEGRITY_TREE_NODE_ADDRESS_WALK_DEFINES_SVH
`define INTEGRITY_TREE_NODE_ADDRESS_WALK_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ITNA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itna: same-cycle check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ITNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itna: next-cycle check failed");

`endif

### rtl/core/itna_pkg.sv
// ----------------------------------------------------------------------------
// itna_pkg
// Types and constants shared by the tree node address walk modules.
// ----------------------------------------------------------------------------
package itna_pkg;

   // field widths
   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 13;
   localparam int PK_W     = 7;
   localparam int LVL_W    = 5;
   localparam int OFF_W    = 6;
   localparam int LVLO_W   = 4;
   localparam int SER_W    = 32;
   localparam int STAT_W   = 2;
   localparam int IDX_W    = 3;

   // node id: interior count plus chunk / 2 needs one bit over the address
   localparam int ID_W     = ADDR_W + 1;
   // divider: two quotient bits per step
   localparam int DIV_W    = 50;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int CNT_W    = 5;
   localparam int PROD_W   = ID_W + SIZE_W;
   localparam int SUM_W    = 64;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
   localparam logic [STAT_W-1:0] ST_DATA_IN_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_NODE_OUT      = 2'd2;

   // configuration register indexes
   localparam logic [IDX_W-1:0] CSR_BASE     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_SIZE     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_BUS      = 3'd2;
   localparam logic [IDX_W-1:0] CSR_PACKING  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_LEVELS   = 3'd4;
   localparam logic [IDX_W-1:0] CSR_NODE     = 3'd5;
   localparam logic [IDX_W-1:0] CSR_INTERIOR = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ERR,
      S_DIV_BUS,
      S_DIV_PK,
      S_MUL,
      S_EMIT,
      S_DIV_UP
   } state_type;

   typedef enum logic [1:0] {
      DSRC_DATA,
      DSRC_CHUNK,
      DSRC_ID
   } div_src_type;

   // controller to datapath
   typedef struct packed {
      logic        latch_req;
      logic        start_walk;
      logic        div_load;
      div_src_type div_src;
      logic        div_step;
      logic        set_leaf;
      logic        set_up;
      logic        mul;
      logic        out_err;
      logic        out_node;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic data_in_range;
      logic div_done;
      logic last_level;
      logic out_free;
   } status_type;

endpackage

### rtl/core/itna_ctrl.sv
// ----------------------------------------------------------------------------
// itna_ctrl
// Sequencer for the walk: range check or error word, two divides to the leaf, then
// per tree level one multiply and one result word, with a divide between levels.
// ----------------------------------------------------------------------------
module itna_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  itna_pkg::status_type stat,
   output itna_pkg::cmd_type    cmd
);

   itna_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itna_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != itna_pkg::S_IDLE);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_src = itna_pkg::DSRC_DATA;
      case (state_ff)
         itna_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = itna_pkg::S_CHECK;
            end
         end
         itna_pkg::S_CHECK: begin
            if (stat.data_in_range) begin
               state_in = itna_pkg::S_ERR;
            end else begin
               cmd.start_walk = 1'b1;
               cmd.div_load   = 1'b1;
               cmd.div_src    = itna_pkg::DSRC_DATA;
               state_in       = itna_pkg::S_DIV_BUS;
            end
         end
         itna_pkg::S_ERR: begin
            if (stat.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = itna_pkg::S_IDLE;
            end
         end
         itna_pkg::S_DIV_BUS: begin
            if (stat.div_done) begin
               cmd.div_load = 1'b1;
               cmd.div_src  = itna_pkg::DSRC_CHUNK;
               state_in     = itna_pkg::S_DIV_PK;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         itna_pkg::S_DIV_PK: begin
            if (stat.div_done) begin
               cmd.set_leaf = 1'b1;
               state_in     = itna_pkg::S_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         itna_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = itna_pkg::S_EMIT;
         end
         itna_pkg::S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_node = 1'b1;
               if (stat.last_level) begin
                  state_in = itna_pkg::S_IDLE;
               end else begin
                  cmd.div_load = 1'b1;
                  cmd.div_src  = itna_pkg::DSRC_ID;
                  state_in     = itna_pkg::S_DIV_UP;
               end
            end
         end
         itna_pkg::S_DIV_UP: begin
            if (stat.div_done) begin
               cmd.set_up = 1'b1;
               state_in   = itna_pkg::S_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         default: begin
            state_in = itna_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/itna_dpath.sv
// ----------------------------------------------------------------------------
// itna_dpath
// Configuration registers, serial counter, shared radix-4 divider, node
// address multiply-add, range checks and the result output register.
// ----------------------------------------------------------------------------
module itna_dpath #(
   parameter int ADDRESS_WIDTH = 48,
   parameter int MAX_LEVELS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [itna_pkg::IDX_W-1:0]    csr_index,
   input  logic [itna_pkg::ADDR_W-1:0]   csr_wr_data,
   // request payload
   input  logic [itna_pkg::ADDR_W-1:0]   req_data_address,
   input  logic                          req_is_read,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itna_pkg::ADDR_W-1:0]   rsp_node_address,
   output logic [itna_pkg::OFF_W-1:0]    rsp_node_offset,
   output logic [itna_pkg::LVLO_W-1:0]   rsp_level,
   output logic [itna_pkg::SER_W-1:0]    rsp_request_serial,
   output logic                          rsp_read_flag,
   output logic [itna_pkg::STAT_W-1:0]   rsp_status,
   output logic                          rsp_last,
   // control
   input  itna_pkg::cmd_type             cmd,
   output itna_pkg::status_type          stat
);

   localparam int MASK_W = (ADDRESS_WIDTH < itna_pkg::ADDR_W) ? ADDRESS_WIDTH
                                                              : itna_pkg::ADDR_W;
   localparam logic [itna_pkg::ADDR_W-1:0] ADDR_MASK =
      itna_pkg::ADDR_W'((65'd1 << MASK_W) - 65'd1);

   // configuration registers
   logic [itna_pkg::ADDR_W-1:0] base_ff, size_ff, inc_ff;
   logic [itna_pkg::SIZE_W-1:0] bus_ff, nb_ff;
   logic [itna_pkg::PK_W-1:0]   pk_ff;
   logic [itna_pkg::LVL_W-1:0]  tl_ff;

   // request and walk state
   logic [itna_pkg::ADDR_W-1:0] data_ff;
   logic                        rd_ff;
   logic [itna_pkg::SER_W-1:0]  serial_ff, req_ser_ff;
   logic [itna_pkg::ID_W-1:0]   id_ff;
   logic [itna_pkg::OFF_W-1:0]  off_ff;
   logic [itna_pkg::LVL_W-1:0]  lvl_ff;
   logic [itna_pkg::PROD_W-1:0] prod_ff;

   // divider
   logic [itna_pkg::SIZE_W-1:0] rem_ff, rem_in, divisor_ff;
   logic [itna_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [itna_pkg::CNT_W-1:0]  cnt_ff;

   // output register
   logic                        rsp_valid_ff;
   logic [itna_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic [itna_pkg::OFF_W-1:0]  rsp_off_ff;
   logic [itna_pkg::LVLO_W-1:0] rsp_lvl_ff;
   logic [itna_pkg::SER_W-1:0]  rsp_ser_ff;
   logic                        rsp_rd_ff;
   logic [itna_pkg::STAT_W-1:0] rsp_stat_ff;
   logic                        rsp_last_ff;

   // effective configuration
   logic [itna_pkg::SIZE_W-1:0] bus_eff, pk_eff;
   logic [itna_pkg::LVL_W-1:0]  lvl_cnt_eff;
   logic [itna_pkg::SUM_W-1:0]  node_sum;

   always_comb begin
      bus_eff = (bus_ff == '0) ? itna_pkg::SIZE_W'(1) : bus_ff;
      if (pk_ff < itna_pkg::PK_W'(2)) begin
         pk_eff = itna_pkg::SIZE_W'(2);
      end else if (pk_ff > itna_pkg::PK_W'(64)) begin
         pk_eff = itna_pkg::SIZE_W'(64);
      end else begin
         pk_eff = itna_pkg::SIZE_W'(pk_ff);
      end
      if (tl_ff == '0) begin
         lvl_cnt_eff = itna_pkg::LVL_W'(1);
      end else if (32'(tl_ff) > MAX_LEVELS) begin
         lvl_cnt_eff = itna_pkg::LVL_W'(MAX_LEVELS);
      end else begin
         lvl_cnt_eff = tl_ff;
      end
   end

   // status back to the controller
   assign stat.data_in_range = (data_ff >= base_ff) && ((data_ff - base_ff) < size_ff);
   assign stat.div_done      = (cnt_ff == itna_pkg::CNT_W'(itna_pkg::DIV_STEPS));
   assign stat.last_level    = ((lvl_ff + itna_pkg::LVL_W'(1)) == lvl_cnt_eff);
   assign stat.out_free      = !rsp_valid_ff || !rsp_stall;

   // node address: base plus id * node_bytes, never wraps in 64 bits
   assign node_sum = itna_pkg::SUM_W'(base_ff) + itna_pkg::SUM_W'(prod_ff);

   // two restoring divide steps per cycle
   always_comb begin
      logic [itna_pkg::SIZE_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < 2; k++) begin
         trial  = {rem_in, quo_in[itna_pkg::DIV_W-1]};
         quo_in = {quo_in[itna_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial     = trial - {1'b0, divisor_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[itna_pkg::SIZE_W-1:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= '0;
         bus_ff  <= itna_pkg::SIZE_W'(64);
         pk_ff   <= itna_pkg::PK_W'(8);
         tl_ff   <= itna_pkg::LVL_W'(4);
         nb_ff   <= itna_pkg::SIZE_W'(64);
         inc_ff  <= itna_pkg::ADDR_W'(585);
      end else if (csr_wr_en) begin
         case (csr_index)
            itna_pkg::CSR_BASE:     base_ff <= csr_wr_data;
            itna_pkg::CSR_SIZE:     size_ff <= csr_wr_data;
            itna_pkg::CSR_BUS:      bus_ff  <= csr_wr_data[itna_pkg::SIZE_W-1:0];
            itna_pkg::CSR_PACKING:  pk_ff   <= csr_wr_data[itna_pkg::PK_W-1:0];
            itna_pkg::CSR_LEVELS:   tl_ff   <= csr_wr_data[itna_pkg::LVL_W-1:0];
            itna_pkg::CSR_NODE:     nb_ff   <= csr_wr_data[itna_pkg::SIZE_W-1:0];
            itna_pkg::CSR_INTERIOR: inc_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // serial counter
   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= '0;
      end else if (cmd.start_walk) begin
         serial_ff <= serial_ff + itna_pkg::SER_W'(1);
      end
   end

   // request capture, divider and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_load) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + itna_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         data_ff    <= req_data_address & ADDR_MASK;
         rd_ff      <= req_is_read;
         req_ser_ff <= serial_ff;
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         case (cmd.div_src)
            itna_pkg::DSRC_DATA: begin
               quo_ff     <= itna_pkg::DIV_W'(data_ff);
               divisor_ff <= bus_eff;
            end
            itna_pkg::DSRC_CHUNK: begin
               quo_ff     <= quo_ff;
               divisor_ff <= pk_eff;
            end
            itna_pkg::DSRC_ID: begin
               quo_ff     <= itna_pkg::DIV_W'(id_ff);
               divisor_ff <= pk_eff;
            end
            default: begin
               quo_ff     <= quo_ff;
               divisor_ff <= pk_eff;
            end
         endcase
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.set_leaf) begin
         id_ff  <= itna_pkg::ID_W'(inc_ff) + quo_ff[itna_pkg::ID_W-1:0];
         off_ff <= rem_ff[itna_pkg::OFF_W-1:0];
         lvl_ff <= '0;
      end else if (cmd.set_up) begin
         id_ff  <= quo_ff[itna_pkg::ID_W-1:0];
         off_ff <= rem_ff[itna_pkg::OFF_W-1:0];
         lvl_ff <= lvl_ff + itna_pkg::LVL_W'(1);
      end
      if (cmd.mul) begin
         prod_ff <= itna_pkg::PROD_W'(id_ff) * itna_pkg::PROD_W'(nb_ff);
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_err || cmd.out_node) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_err) begin
         rsp_addr_ff <= '0;
         rsp_off_ff  <= '0;
         rsp_lvl_ff  <= '0;
         rsp_ser_ff  <= req_ser_ff;
         rsp_rd_ff   <= rd_ff;
         rsp_stat_ff <= itna_pkg::ST_DATA_IN_RANGE;
         rsp_last_ff <= 1'b1;
      end else if (cmd.out_node) begin
         rsp_addr_ff <= node_sum[itna_pkg::ADDR_W-1:0] & ADDR_MASK;
         rsp_off_ff  <= off_ff;
         rsp_lvl_ff  <= lvl_ff[itna_pkg::LVLO_W-1:0];
         rsp_ser_ff  <= req_ser_ff;
         rsp_rd_ff   <= rd_ff;
         rsp_stat_ff <= (itna_pkg::SUM_W'(prod_ff) < itna_pkg::SUM_W'(size_ff))
                        ? itna_pkg::ST_OK : itna_pkg::ST_NODE_OUT;
         rsp_last_ff <= stat.last_level;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node_address   = rsp_addr_ff;
   assign rsp_node_offset    = rsp_off_ff;
   assign rsp_level          = rsp_lvl_ff;
   assign rsp_request_serial = rsp_ser_ff;
   assign rsp_read_flag      = rsp_rd_ff;
   assign rsp_status         = rsp_stat_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

### rtl/core/integrity_tree_node_address_walk.sv
// ----------------------------------------------------------------------------
// integrity_tree_node_address_walk
// Maps a protected data address to its counter tree node addresses, one
// result word per level from the leaf upward.
// ----------------------------------------------------------------------------
// One request word at a time. A data address inside the integrity range
// returns a single error word. Otherwise the walk passes acceptance and the
// range check, then two divides in the shared divider (address over the
// counter granule, then over the tree arity), then per level a multiply and
// an output, with a divide between levels; the result side can stall the
// output. The divider retires two quotient bits per cycle and sets the
// pace.
// A new request is taken once the final word sits in the output register.
module integrity_tree_node_address_walk #(
   parameter int ADDRESS_WIDTH = 48,
   parameter int MAX_LEVELS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [itna_pkg::IDX_W-1:0]    csr_index,
   input  logic [itna_pkg::ADDR_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itna_pkg::ADDR_W-1:0]   req_data_address,
   input  logic                          req_is_read,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itna_pkg::ADDR_W-1:0]   rsp_node_address,
   output logic [itna_pkg::OFF_W-1:0]    rsp_node_offset,
   output logic [itna_pkg::LVLO_W-1:0]   rsp_level,
   output logic [itna_pkg::SER_W-1:0]    rsp_request_serial,
   output logic                          rsp_read_flag,
   output logic [itna_pkg::STAT_W-1:0]   rsp_status,
   output logic                          rsp_last
);

   itna_pkg::cmd_type    cmd;
   itna_pkg::status_type stat;

   // sequencer
   itna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic and registers
   itna_dpath #(
      .ADDRESS_WIDTH (ADDRESS_WIDTH),
      .MAX_LEVELS    (MAX_LEVELS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_data_address   (req_data_address),
      .req_is_read        (req_is_read),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_node_address   (rsp_node_address),
      .rsp_node_offset    (rsp_node_offset),
      .rsp_level          (rsp_level),
      .rsp_request_serial (rsp_request_serial),
      .rsp_read_flag      (rsp_read_flag),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

### rtl/core/itna_checker.sv
// ----------------------------------------------------------------------------
// itna_port_checks
// Port-level checks for the tree node address walk, bound to the top level.
// ----------------------------------------------------------------------------
`include "integrity_tree_node_address_walk_defines.svh"

module itna_port_checks (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [itna_pkg::ADDR_W-1:0]   rsp_node_address,
   input logic [itna_pkg::LVLO_W-1:0]   rsp_level,
   input logic [itna_pkg::STAT_W-1:0]   rsp_status,
   input logic                          rsp_last
);

   // a stalled result word stays
   `ITNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ITNA_ASSERT_NEXT(a_rsp_addr_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_node_address))
   // an accepted request keeps the block busy for at least the next cycle
   `ITNA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // error words are single, at the leaf, with a zero address
   `ITNA_ASSERT_NOW(a_err_word, clock, reset, rsp_valid && (rsp_status == itna_pkg::ST_DATA_IN_RANGE), rsp_last && (rsp_level == '0) && (rsp_node_address == '0))

endmodule

bind integrity_tree_node_address_walk itna_port_checks u_itna_checker (.*);
